@@ hdl/i2cseq_pkg.sv @@
// Shared types and constants for the I2C master transfer sequencer.
package i2cseq_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [3:0] MaxRetriesReset = 4'd3;
  localparam logic       RegIdxMaxRetries = 1'b0;

  localparam logic [7:0] StatStart     = 8'h08;
  localparam logic [7:0] StatRepStart  = 8'h10;
  localparam logic [7:0] StatWAddrAck  = 8'h18;
  localparam logic [7:0] StatWAddrNack = 8'h20;
  localparam logic [7:0] StatWDataAck  = 8'h28;
  localparam logic [7:0] StatWDataNack = 8'h30;
  localparam logic [7:0] StatArbLost   = 8'h38;
  localparam logic [7:0] StatRAddrAck  = 8'h40;
  localparam logic [7:0] StatRAddrNack = 8'h48;
  localparam logic [7:0] StatRDataAck  = 8'h50;
  localparam logic [7:0] StatRDataNack = 8'h58;

  typedef enum logic [3:0] {
    CLS_START,
    CLS_ARB,
    CLS_WADDR_ACK,
    CLS_WADDR_NACK,
    CLS_WDATA_DONE,
    CLS_RADDR_ACK,
    CLS_RADDR_NACK,
    CLS_RDATA_ACK,
    CLS_RDATA_NACK,
    CLS_OTHER
  } status_e;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_START,
    PH_ADDR,
    PH_TX,
    PH_RX
  } phase_e;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_SEND  = 3'd2,
    CMD_RACK  = 3'd3,
    CMD_RNACK = 3'd4,
    CMD_STOP  = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    RES_OK      = 3'd0,
    RES_UNEXP   = 3'd1,
    RES_NACK    = 3'd2,
    RES_ARB     = 3'd3,
    RES_UNKNOWN = 3'd4
  } res_e;

  typedef enum logic {
    KIND_BEGIN = 1'b0,
    KIND_EVENT = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  slave_addr;
    logic        is_read;
    logic [7:0]  byte_count;
    status_e     cls;
    logic [7:0]  rx_byte;
    logic [7:0]  tx_byte;
  } entry_t;

  typedef struct packed {
    cmd_e        bus_command;
    logic [7:0]  bus_byte;
    logic        rx_valid;
    logic [7:0]  rx_data;
    logic [7:0]  rx_index;
    logic        done_res;
    res_e        result_code;
  } result_t;

  function automatic status_e classify(logic [7:0] st);
    status_e c;
    c = CLS_OTHER;
    if (st == StatStart || st == StatRepStart) c = CLS_START;
    else if (st == StatArbLost)   c = CLS_ARB;
    else if (st == StatWAddrAck)  c = CLS_WADDR_ACK;
    else if (st == StatWAddrNack) c = CLS_WADDR_NACK;
    else if (st == StatWDataAck || st == StatWDataNack) c = CLS_WDATA_DONE;
    else if (st == StatRAddrAck)  c = CLS_RADDR_ACK;
    else if (st == StatRAddrNack) c = CLS_RADDR_NACK;
    else if (st == StatRDataAck)  c = CLS_RDATA_ACK;
    else if (st == StatRDataNack) c = CLS_RDATA_NACK;
    return c;
  endfunction

endpackage

@@ hdl/i2c_master_transfer_sequencer.sv @@
// Top level of the I2C master transfer sequencer: queues, configuration and sequencing.
// Each accepted item, a begin command or a bus status event, yields exactly one result
// item holding the next bus engine command and, when the transfer ends, its outcome.
// Items flow at one per clock cycle while results are popped: the front end classifies
// the status code and places the item in a two-entry queue; the back end state machine
// consumes one queued item per cycle into a result register that frees when it is popped.
// The max_retries register sits at byte address 0 of the configuration port and must
// only be written while no transfer items are in flight.
module i2c_master_transfer_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        kind_i,
  input  logic [7:0]  slave_addr_i,
  input  logic        is_read_i,
  input  logic [7:0]  byte_count_i,
  input  logic [7:0]  bus_status_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [7:0]  tx_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  bus_command_o,
  output logic [7:0]  bus_byte_o,
  output logic        rx_valid_o,
  output logic [7:0]  rx_data_o,
  output logic [7:0]  rx_index_o,
  output logic        done_res_o,
  output logic [2:0]  result_code_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [3:0]          max_retries_r_q, max_retries_d;
  logic                cfg_wr;
  logic                entry_valid;
  logic                entry_pop;
  i2cseq_pkg::entry_t  entry;
  logic                res_valid;
  i2cseq_pkg::result_t res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == i2cseq_pkg::RegIdxMaxRetries);

  always_comb begin
    max_retries_d = max_retries_r_q;
    if (cfg_wr) begin
      max_retries_d = pwdata[3:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_retries_r_q <= i2cseq_pkg::MaxRetriesReset;
    end else begin
      max_retries_r_q <= max_retries_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == i2cseq_pkg::RegIdxMaxRetries) begin
      prdata = {28'd0, max_retries_r_q};
    end
  end

  i2cseq_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .kind_i        (kind_i),
    .slave_addr_i  (slave_addr_i),
    .is_read_i     (is_read_i),
    .byte_count_i  (byte_count_i),
    .bus_status_i  (bus_status_i),
    .rx_byte_i     (rx_byte_i),
    .tx_byte_i     (tx_byte_i),
    .entry_valid_o (entry_valid),
    .entry_o       (entry),
    .entry_pop_i   (entry_pop)
  );

  i2cseq_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .max_retries_i (max_retries_r_q),
    .entry_valid_i (entry_valid),
    .entry_i       (entry),
    .entry_pop_o   (entry_pop),
    .res_valid_o   (res_valid),
    .res_o         (res),
    .res_pop_i     (pop)
  );

  assign empty         = !res_valid;
  assign bus_command_o = res.bus_command;
  assign bus_byte_o    = res.bus_byte;
  assign rx_valid_o    = res.rx_valid;
  assign rx_data_o     = res.rx_data;
  assign rx_index_o    = res.rx_index;
  assign done_res_o    = res.done_res;
  assign result_code_o = res.result_code;

endmodule

@@ hdl/i2cseq_front.sv @@
// Front end: classifies incoming items and holds them in a short queue.
module i2cseq_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  output logic                  full_o,
  input  logic                  kind_i,
  input  logic [7:0]            slave_addr_i,
  input  logic                  is_read_i,
  input  logic [7:0]            byte_count_i,
  input  logic [7:0]            bus_status_i,
  input  logic [7:0]            rx_byte_i,
  input  logic [7:0]            tx_byte_i,
  output logic                  entry_valid_o,
  output i2cseq_pkg::entry_t    entry_o,
  input  logic                  entry_pop_i
);

  i2cseq_pkg::entry_t                       mem_q [i2cseq_pkg::QueueDepth];
  logic [i2cseq_pkg::QueuePtrW-1:0]         wr_ptr_q, wr_ptr_d;
  logic [i2cseq_pkg::QueuePtrW-1:0]         rd_ptr_q, rd_ptr_d;
  logic [i2cseq_pkg::QueueCntW-1:0]         count_q, count_d;
  logic                                     do_push, do_pop;
  i2cseq_pkg::entry_t                       new_entry;

  assign full_o        = (count_q == i2cseq_pkg::QueueCntW'(i2cseq_pkg::QueueDepth));
  assign entry_valid_o = (count_q != '0);
  assign do_push       = push_i && !full_o;
  assign do_pop        = entry_pop_i && entry_valid_o;
  assign entry_o       = mem_q[rd_ptr_q];

  always_comb begin
    new_entry.kind       = i2cseq_pkg::kind_e'(kind_i);
    new_entry.slave_addr = slave_addr_i;
    new_entry.is_read    = is_read_i;
    new_entry.byte_count = byte_count_i;
    new_entry.cls        = i2cseq_pkg::classify(bus_status_i);
    new_entry.rx_byte    = rx_byte_i;
    new_entry.tx_byte    = tx_byte_i;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == i2cseq_pkg::QueuePtrW'(i2cseq_pkg::QueueDepth - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == i2cseq_pkg::QueuePtrW'(i2cseq_pkg::QueueDepth - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= new_entry;
    end
  end

endmodule

@@ hdl/i2cseq_back.sv @@
// Back end: transfer state machine and the registered result stage.
module i2cseq_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [3:0]            max_retries_i,
  input  logic                  entry_valid_i,
  input  i2cseq_pkg::entry_t    entry_i,
  output logic                  entry_pop_o,
  output logic                  res_valid_o,
  output i2cseq_pkg::result_t   res_o,
  input  logic                  res_pop_i
);

  i2cseq_pkg::phase_e  phase_q, phase_d;
  logic                reading_q, reading_d;
  logic [7:0]          addr_q, addr_d;
  logic [7:0]          total_q, total_d;
  logic [7:0]          pos_q, pos_d;
  logic [3:0]          retry_q, retry_d;
  logic                out_valid_q, out_valid_d;
  i2cseq_pkg::result_t out_q, res_d;
  logic                take;
  logic [7:0]          pos_inc;
  logic [7:0]          eff_total;
  logic                rx_last;
  logic                rx_next_last;

  assign take        = entry_valid_i && (!out_valid_q || res_pop_i);
  assign entry_pop_o = take;
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  assign pos_inc      = pos_q + 8'd1;
  assign eff_total    = (total_q == 8'd0) ? 8'd1 : total_q;
  assign rx_last      = ({1'b0, pos_q} + 9'd1) >= {1'b0, eff_total};
  assign rx_next_last = ({1'b0, pos_q} + 9'd2) >= {1'b0, eff_total};

  always_comb begin
    phase_d   = phase_q;
    reading_d = reading_q;
    addr_d    = addr_q;
    total_d   = total_q;
    pos_d     = pos_q;
    retry_d   = retry_q;
    res_d     = '0;
    res_d.bus_command = i2cseq_pkg::CMD_NONE;
    res_d.result_code = i2cseq_pkg::RES_OK;

    if (entry_i.kind == i2cseq_pkg::KIND_BEGIN) begin
      addr_d    = entry_i.slave_addr;
      reading_d = entry_i.is_read;
      total_d   = entry_i.byte_count;
      pos_d     = '0;
      retry_d   = '0;
      phase_d   = i2cseq_pkg::PH_START;
      res_d.bus_command = i2cseq_pkg::CMD_START;
    end else begin
      unique case (phase_q)
        i2cseq_pkg::PH_START: begin
          if (entry_i.cls == i2cseq_pkg::CLS_START) begin
            res_d.bus_command = i2cseq_pkg::CMD_SEND;
            res_d.bus_byte    = {addr_q[7:1], reading_q};
            phase_d           = i2cseq_pkg::PH_ADDR;
          end else begin
            res_d.done_res = 1'b1;
            phase_d        = i2cseq_pkg::PH_IDLE;
            if (reading_q) begin
              res_d.result_code = i2cseq_pkg::RES_UNEXP;
            end else if (entry_i.cls == i2cseq_pkg::CLS_ARB) begin
              res_d.bus_command = i2cseq_pkg::CMD_STOP;
              res_d.result_code = i2cseq_pkg::RES_UNEXP;
            end else begin
              res_d.result_code = i2cseq_pkg::RES_UNKNOWN;
            end
          end
        end
        i2cseq_pkg::PH_ADDR: begin
          if (entry_i.cls == i2cseq_pkg::CLS_ARB) begin
            res_d.bus_command = i2cseq_pkg::CMD_STOP;
            res_d.done_res    = 1'b1;
            res_d.result_code = i2cseq_pkg::RES_ARB;
            phase_d           = i2cseq_pkg::PH_IDLE;
          end else if ((!reading_q && entry_i.cls == i2cseq_pkg::CLS_WADDR_NACK) ||
                       (reading_q && entry_i.cls == i2cseq_pkg::CLS_RADDR_NACK)) begin
            if (retry_q < max_retries_i) begin
              retry_d           = retry_q + 4'd1;
              res_d.bus_command = i2cseq_pkg::CMD_START;
              phase_d           = i2cseq_pkg::PH_START;
            end else begin
              res_d.bus_command = i2cseq_pkg::CMD_STOP;
              res_d.done_res    = 1'b1;
              res_d.result_code = i2cseq_pkg::RES_NACK;
              phase_d           = i2cseq_pkg::PH_IDLE;
            end
          end else if (!reading_q && entry_i.cls == i2cseq_pkg::CLS_WADDR_ACK) begin
            if (total_q == 8'd0) begin
              res_d.bus_command = i2cseq_pkg::CMD_STOP;
              res_d.done_res    = 1'b1;
              res_d.result_code = i2cseq_pkg::RES_OK;
              phase_d           = i2cseq_pkg::PH_IDLE;
            end else begin
              res_d.bus_command = i2cseq_pkg::CMD_SEND;
              res_d.bus_byte    = entry_i.tx_byte;
              phase_d           = i2cseq_pkg::PH_TX;
            end
          end else if (reading_q && entry_i.cls == i2cseq_pkg::CLS_RADDR_ACK) begin
            res_d.bus_command = (total_q <= 8'd1) ? i2cseq_pkg::CMD_RNACK :
                                                    i2cseq_pkg::CMD_RACK;
            phase_d           = i2cseq_pkg::PH_RX;
          end else begin
            res_d.done_res    = 1'b1;
            res_d.result_code = i2cseq_pkg::RES_UNKNOWN;
            phase_d           = i2cseq_pkg::PH_IDLE;
          end
        end
        i2cseq_pkg::PH_TX: begin
          if (entry_i.cls == i2cseq_pkg::CLS_WDATA_DONE) begin
            pos_d = pos_inc;
            if (pos_inc >= total_q) begin
              res_d.bus_command = i2cseq_pkg::CMD_STOP;
              res_d.done_res    = 1'b1;
              res_d.result_code = i2cseq_pkg::RES_OK;
              phase_d           = i2cseq_pkg::PH_IDLE;
            end else begin
              res_d.bus_command = i2cseq_pkg::CMD_SEND;
              res_d.bus_byte    = entry_i.tx_byte;
            end
          end else if (entry_i.cls == i2cseq_pkg::CLS_ARB) begin
            res_d.bus_command = i2cseq_pkg::CMD_STOP;
            res_d.done_res    = 1'b1;
            res_d.result_code = i2cseq_pkg::RES_ARB;
            phase_d           = i2cseq_pkg::PH_IDLE;
          end else begin
            res_d.done_res    = 1'b1;
            res_d.result_code = i2cseq_pkg::RES_UNKNOWN;
            phase_d           = i2cseq_pkg::PH_IDLE;
          end
        end
        i2cseq_pkg::PH_RX: begin
          res_d.rx_valid = 1'b1;
          res_d.rx_data  = entry_i.rx_byte;
          res_d.rx_index = pos_q;
          if (entry_i.cls == i2cseq_pkg::CLS_ARB) begin
            res_d.bus_command = i2cseq_pkg::CMD_STOP;
            res_d.done_res    = 1'b1;
            res_d.result_code = i2cseq_pkg::RES_ARB;
            phase_d           = i2cseq_pkg::PH_IDLE;
          end else if (entry_i.cls == i2cseq_pkg::CLS_RDATA_ACK) begin
            if (rx_last) begin
              res_d.bus_command = i2cseq_pkg::CMD_STOP;
              res_d.done_res    = 1'b1;
              res_d.result_code = i2cseq_pkg::RES_UNEXP;
              phase_d           = i2cseq_pkg::PH_IDLE;
            end else begin
              pos_d             = pos_inc;
              res_d.bus_command = rx_next_last ? i2cseq_pkg::CMD_RNACK :
                                                 i2cseq_pkg::CMD_RACK;
            end
          end else if (entry_i.cls == i2cseq_pkg::CLS_RDATA_NACK) begin
            res_d.bus_command = i2cseq_pkg::CMD_STOP;
            res_d.done_res    = 1'b1;
            res_d.result_code = rx_last ? i2cseq_pkg::RES_OK : i2cseq_pkg::RES_NACK;
            phase_d           = i2cseq_pkg::PH_IDLE;
          end else begin
            res_d.done_res    = 1'b1;
            res_d.result_code = i2cseq_pkg::RES_UNKNOWN;
            phase_d           = i2cseq_pkg::PH_IDLE;
          end
        end
        default: begin
          phase_d = i2cseq_pkg::PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
    end else if (res_pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= i2cseq_pkg::PH_IDLE;
      reading_q   <= 1'b0;
      addr_q      <= '0;
      total_q     <= '0;
      pos_q       <= '0;
      retry_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take) begin
        phase_q   <= phase_d;
        reading_q <= reading_d;
        addr_q    <= addr_d;
        total_q   <= total_d;
        pos_q     <= pos_d;
        retry_q   <= retry_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= res_d;
    end
  end

endmodule

@@ hdl/i2cseq_checker.sv @@
// Port-level checks for the I2C master transfer sequencer, bound to the top level.
module i2cseq_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [2:0] bus_command_o,
  input logic [7:0] bus_byte_o,
  input logic       rx_valid_o,
  input logic [7:0] rx_data_o,
  input logic [7:0] rx_index_o,
  input logic       done_res_o,
  input logic [2:0] result_code_o
);

  // An unfinished transfer never reports an outcome.
  a_code_only_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !done_res_o) |-> (result_code_o == i2cseq_pkg::RES_OK))
    else $error("result code set without done");

  // Received data fields are zero unless a byte is delivered.
  a_rx_fields_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !rx_valid_o) |-> (rx_data_o == 8'd0 && rx_index_o == 8'd0))
    else $error("rx fields set without rx_valid");

  // The bus byte is only used by a send command.
  a_byte_only_on_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && bus_command_o != i2cseq_pkg::CMD_SEND) |-> (bus_byte_o == 8'd0))
    else $error("bus byte set without send command");

  // A finished transfer issues either stop or nothing.
  a_done_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && done_res_o) |->
    (bus_command_o == i2cseq_pkg::CMD_STOP || bus_command_o == i2cseq_pkg::CMD_NONE))
    else $error("done with an unexpected command");

  // A waiting item holds until it is popped.
  a_hold_until_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(bus_command_o) && $stable(bus_byte_o) &&
                          $stable(done_res_o) && $stable(result_code_o)))
    else $error("result item changed while waiting");

endmodule

bind i2c_master_transfer_sequencer i2cseq_checker u_i2cseq_checker (.*);

@@ bench/i2cseq_action_checker.sv @@
// Checker that predicts every result item of the I2C transfer sequencer and compares it with the block.
module i2cseq_action_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  logic        full,
  input  logic        kind_i,
  input  logic [7:0]  slave_addr_i,
  input  logic        is_read_i,
  input  logic [7:0]  byte_count_i,
  input  logic [7:0]  bus_status_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [7:0]  tx_byte_i,
  input  logic        empty,
  input  logic        pop,
  input  logic [2:0]  bus_command_o,
  input  logic [7:0]  bus_byte_o,
  input  logic        rx_valid_o,
  input  logic [7:0]  rx_data_o,
  input  logic [7:0]  rx_index_o,
  input  logic        done_res_o,
  input  logic [2:0]  result_code_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import i2cseq_pkg::*;

  localparam logic [2:0] RetryLimitAddr = {RegIdxMaxRetries, 2'b00};

  phase_e     seq_phase;
  logic       xfer_read;
  logic [7:0] xfer_addr;
  logic [7:0] xfer_total;
  logic [7:0] xfer_pos;
  logic [3:0] retry_used;
  logic [3:0] retry_limit;
  result_t    due_actions[$];
  result_t    oldest_due;

  function automatic result_t closing(logic send_stop, res_e code);
    result_t r;
    r = '0;
    if (send_stop) begin
      r.bus_command = CMD_STOP;
    end else begin
      r.bus_command = CMD_NONE;
    end
    r.done_res = 1'b1;
    r.result_code = code;
    seq_phase = PH_IDLE;
    return r;
  endfunction

  function automatic result_t next_bus_action(logic kind, logic [7:0] addr, logic rd,
                                              logic [7:0] cnt, logic [7:0] st,
                                              logic [7:0] rxb, logic [7:0] txb);
    result_t    r;
    logic [8:0] eff;
    logic       last;
    logic [7:0] rx_pos;
    r = '0;
    if (kind == KIND_BEGIN) begin
      xfer_addr = addr;
      xfer_read = rd;
      xfer_total = cnt;
      xfer_pos = '0;
      retry_used = '0;
      seq_phase = PH_START;
      r.bus_command = CMD_START;
    end else begin
      case (seq_phase)
        PH_START: begin
          if (st == StatStart || st == StatRepStart) begin
            r.bus_command = CMD_SEND;
            r.bus_byte = {xfer_addr[7:1], xfer_read};
            seq_phase = PH_ADDR;
          end else if (xfer_read) begin
            r = closing(1'b0, RES_UNEXP);
          end else if (st == StatArbLost) begin
            r = closing(1'b1, RES_UNEXP);
          end else begin
            r = closing(1'b0, RES_UNKNOWN);
          end
        end
        PH_ADDR: begin
          if (st == StatArbLost) begin
            r = closing(1'b1, RES_ARB);
          end else if ((!xfer_read && st == StatWAddrNack) ||
                       (xfer_read && st == StatRAddrNack)) begin
            if (retry_used < retry_limit) begin
              retry_used = retry_used + 4'd1;
              r.bus_command = CMD_START;
              seq_phase = PH_START;
            end else begin
              r = closing(1'b1, RES_NACK);
            end
          end else if (!xfer_read && st == StatWAddrAck) begin
            if (xfer_total == 8'd0) begin
              r = closing(1'b1, RES_OK);
            end else begin
              r.bus_command = CMD_SEND;
              r.bus_byte = txb;
              seq_phase = PH_TX;
            end
          end else if (xfer_read && st == StatRAddrAck) begin
            if (xfer_total <= 8'd1) begin
              r.bus_command = CMD_RNACK;
            end else begin
              r.bus_command = CMD_RACK;
            end
            seq_phase = PH_RX;
          end else begin
            r = closing(1'b0, RES_UNKNOWN);
          end
        end
        PH_TX: begin
          if (st == StatWDataAck || st == StatWDataNack) begin
            xfer_pos = xfer_pos + 8'd1;
            if (xfer_pos >= xfer_total) begin
              r = closing(1'b1, RES_OK);
            end else begin
              r.bus_command = CMD_SEND;
              r.bus_byte = txb;
            end
          end else if (st == StatArbLost) begin
            r = closing(1'b1, RES_ARB);
          end else begin
            r = closing(1'b0, RES_UNKNOWN);
          end
        end
        PH_RX: begin
          rx_pos = xfer_pos;
          eff = (xfer_total == 8'd0) ? 9'd1 : {1'b0, xfer_total};
          last = ({1'b0, xfer_pos} + 9'd1) >= eff;
          if (st == StatArbLost) begin
            r = closing(1'b1, RES_ARB);
          end else if (st == StatRDataAck) begin
            if (last) begin
              r = closing(1'b1, RES_UNEXP);
            end else begin
              xfer_pos = xfer_pos + 8'd1;
              if (({1'b0, xfer_pos} + 9'd1) >= eff) begin
                r.bus_command = CMD_RNACK;
              end else begin
                r.bus_command = CMD_RACK;
              end
            end
          end else if (st == StatRDataNack) begin
            if (last) begin
              r = closing(1'b1, RES_OK);
            end else begin
              r = closing(1'b1, RES_NACK);
            end
          end else begin
            r = closing(1'b0, RES_UNKNOWN);
          end
          r.rx_valid = 1'b1;
          r.rx_data = rxb;
          r.rx_index = rx_pos;
        end
        default: begin
          seq_phase = PH_IDLE;
        end
      endcase
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fail_count_o = fail_count_o + 1;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_phase = PH_IDLE;
      xfer_read = 1'b0;
      xfer_addr = '0;
      xfer_total = '0;
      xfer_pos = '0;
      retry_used = '0;
      retry_limit = MaxRetriesReset;
      due_actions.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (psel && penable && pready && paddr == RetryLimitAddr) begin
        if (pwrite) begin
          retry_limit = pwdata[3:0];
        end else begin
          check_field("prdata", {28'd0, retry_limit}, prdata);
        end
      end
      if (push && !full) begin
        due_actions.push_back(next_bus_action(kind_i, slave_addr_i, is_read_i, byte_count_i,
                                              bus_status_i, rx_byte_i, tx_byte_i));
      end
      if (pop && !empty) begin
        if (due_actions.size() == 0) begin
          $error("result item arrived with no expectation waiting");
          fail_count_o = fail_count_o + 1;
        end else begin
          oldest_due = due_actions.pop_front();
          check_field("bus_command", oldest_due.bus_command, bus_command_o);
          check_field("bus_byte", oldest_due.bus_byte, bus_byte_o);
          check_field("rx_valid", oldest_due.rx_valid, rx_valid_o);
          check_field("rx_data", oldest_due.rx_data, rx_data_o);
          check_field("rx_index", oldest_due.rx_index, rx_index_o);
          check_field("done_res", oldest_due.done_res, done_res_o);
          check_field("result_code", oldest_due.result_code, result_code_o);
        end
      end
      pending_o = due_actions.size();
    end
  end

endmodule

@@ bench/tb.sv @@
// Testbench top: drives transfers, status events and register accesses into the sequencer.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cseq_pkg::*;

  localparam logic [2:0] RetryLimitAddr = {RegIdxMaxRetries, 2'b00};
  localparam int CycleLimit = 200000;

  typedef enum logic [1:0] {
    POP_FREE,
    POP_LIGHT,
    POP_HEAVY,
    POP_PULSED
  } pop_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic        kind_i = 1'b0;
  logic [7:0]  slave_addr_i = '0;
  logic        is_read_i = 1'b0;
  logic [7:0]  byte_count_i = '0;
  logic [7:0]  bus_status_i = '0;
  logic [7:0]  rx_byte_i = '0;
  logic [7:0]  tx_byte_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  bus_command_o;
  logic [7:0]  bus_byte_o;
  logic        rx_valid_o;
  logic [7:0]  rx_data_o;
  logic [7:0]  rx_index_o;
  logic        done_res_o;
  logic [2:0]  result_code_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count_o;
  int          pending_o;

  int          cycle_count = 0;
  int          items_sent = 0;
  int          burst_left = 0;
  int          cur_limit = 3;
  pop_mode_e   pop_mode = POP_FREE;
  int          pop_window = 0;

  i2c_master_transfer_sequencer dut (.*);

  i2cseq_action_checker checker_i (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (pop_window == 0) begin
      pop_mode <= pop_mode_e'($urandom_range(0, 3));
      pop_window <= $urandom_range(16, 80);
    end else begin
      pop_window <= pop_window - 1;
    end
    case (pop_mode)
      POP_FREE:   pop <= 1'b1;
      POP_LIGHT:  pop <= ($urandom_range(0, 3) != 0);
      POP_HEAVY:  pop <= ($urandom_range(0, 3) == 0);
      default:    pop <= pop_window[2];
    endcase
  end

  task automatic put_item(logic k, logic [7:0] addr, logic rd, logic [7:0] cnt,
                          logic [7:0] st, logic [7:0] rxb, logic [7:0] txb);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk_i);
        push <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    push <= 1'b1;
    kind_i <= k;
    slave_addr_i <= addr;
    is_read_i <= rd;
    byte_count_i <= cnt;
    bus_status_i <= st;
    rx_byte_i <= rxb;
    tx_byte_i <= txb;
    items_sent++;
    do @(posedge clk_i); while (full);
  endtask

  task automatic start_transfer(logic [7:0] addr, logic rd, logic [7:0] cnt);
    put_item(KIND_BEGIN, addr, rd, cnt, 8'($urandom()), 8'($urandom()), 8'($urandom()));
  endtask

  task automatic report_status(logic [7:0] st);
    put_item(KIND_EVENT, 8'($urandom()), 1'($urandom()), 8'($urandom()), st,
             8'($urandom()), 8'($urandom()));
  endtask

  task automatic wait_for_results();
    @(negedge clk_i);
    push <= 1'b0;
    burst_left = 0;
    while (pending_o != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic reg_access(logic wr, logic [3:0] v);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= RetryLimitAddr;
    pwdata <= ($urandom() & 32'hFFFF_FFF0) | {28'd0, v};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [7:0] pick_known();
    case ($urandom_range(0, 10))
      0:       return StatStart;
      1:       return StatRepStart;
      2:       return StatWAddrAck;
      3:       return StatWAddrNack;
      4:       return StatWDataAck;
      5:       return StatWDataNack;
      6:       return StatArbLost;
      7:       return StatRAddrAck;
      8:       return StatRAddrNack;
      9:       return StatRDataAck;
      default: return StatRDataNack;
    endcase
  endfunction

  task automatic maybe_noise(output bit quit);
    quit = 1'b0;
    if ($urandom_range(0, 29) == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        start_transfer(8'($urandom()), 1'($urandom()), 8'($urandom()));
      end else if ($urandom_range(0, 1) == 0) begin
        report_status(8'($urandom()));
      end else begin
        report_status(pick_known());
      end
      quit = 1'($urandom());
    end
  endtask

  task automatic run_transfer();
    bit   rd;
    bit   quit;
    int   cnt;
    int   eff;
    int   nacks;
    int   sel;
    sel = $urandom_range(0, 99);
    if (sel < 85) begin
      cnt = $urandom_range(0, 5);
    end else if (sel < 97) begin
      cnt = $urandom_range(6, 40);
    end else begin
      cnt = $urandom_range(200, 255);
    end
    rd = 1'($urandom());
    if ($urandom_range(0, 9) == 0) begin
      nacks = cur_limit + 1;
    end else if ($urandom_range(0, 3) == 0) begin
      nacks = $urandom_range(1, 2);
    end else begin
      nacks = 0;
    end
    start_transfer(8'($urandom()), rd, 8'(cnt));
    for (int a = 0; a <= nacks; a++) begin
      maybe_noise(quit);
      if (quit) return;
      report_status($urandom_range(0, 1) ? StatStart : StatRepStart);
      maybe_noise(quit);
      if (quit) return;
      if (a == nacks) begin
        report_status(rd ? StatRAddrAck : StatWAddrAck);
      end else begin
        report_status(rd ? StatRAddrNack : StatWAddrNack);
        if (a >= cur_limit) return;
      end
    end
    if (rd) begin
      eff = (cnt == 0) ? 1 : cnt;
      for (int i = 0; i < eff; i++) begin
        maybe_noise(quit);
        if (quit) return;
        if ($urandom_range(0, 24) == 0) begin
          report_status((i == eff - 1) ? StatRDataAck : StatRDataNack);
          return;
        end
        report_status((i == eff - 1) ? StatRDataNack : StatRDataAck);
      end
    end else begin
      for (int i = 0; i < cnt; i++) begin
        maybe_noise(quit);
        if (quit) return;
        report_status($urandom_range(0, 1) ? StatWDataAck : StatWDataNack);
      end
    end
  endtask

  initial begin
    logic [3:0] limits [5];
    int         target;
    bit         paused;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    reg_access(1'b0, 4'd0);

    report_status(StatStart);
    start_transfer(8'hFF, 1'b0, 8'd0);
    report_status(StatStart);
    report_status(StatWAddrAck);
    start_transfer(8'h00, 1'b1, 8'd0);
    report_status(StatRepStart);
    report_status(StatRAddrAck);
    report_status(StatRDataNack);
    start_transfer(8'h5A, 1'b0, 8'd2);
    report_status(StatStart);
    report_status(StatWAddrNack);
    report_status(StatStart);
    report_status(StatWAddrAck);
    report_status(StatWDataNack);
    report_status(StatArbLost);
    start_transfer(8'hA5, 1'b1, 8'd3);
    report_status(StatStart);
    start_transfer(8'hA5, 1'b1, 8'd255);
    report_status(StatStart);
    report_status(StatRAddrAck);
    report_status(StatRDataNack);
    start_transfer(8'h3C, 1'b1, 8'd1);
    report_status(StatArbLost);
    start_transfer(8'hC3, 1'b0, 8'd1);
    report_status(StatArbLost);
    start_transfer(8'hC3, 1'b0, 8'd1);
    report_status(8'hFF);

    limits[0] = 4'd0;
    limits[1] = 4'd15;
    limits[2] = 4'($urandom_range(1, 14));
    limits[3] = 4'd1;
    limits[4] = MaxRetriesReset;
    paused = 1'b0;
    for (int p = 0; p < 5; p++) begin
      wait_for_results();
      reg_access(1'b1, limits[p]);
      reg_access(1'b0, 4'd0);
      cur_limit = limits[p];
      target = items_sent + 110;
      while (items_sent < target) begin
        run_transfer();
        if (p == 2 && !paused && items_sent > target - 55) begin
          wait_for_results();
          paused = 1'b1;
        end
      end
    end

    wait_for_results();
    repeat (10) @(posedge clk_i);
    if (fail_count_o == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
